// ===== design/atp_pkg.sv =====
// atp_pkg: shared types, character codes and field layout of the timestamp parser
// used by atp_decode and ascii_timestamp_parser; no dependencies
package atp_pkg;

  localparam int SPAN  = 24;
  localparam int SLOTS = 15;

  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_UA   = 8'h41;  // A
  localparam logic [7:0] CH_UD   = 8'h44;  // D
  localparam logic [7:0] CH_UF   = 8'h46;  // F
  localparam logic [7:0] CH_UJ   = 8'h4A;  // J
  localparam logic [7:0] CH_UM   = 8'h4D;  // M
  localparam logic [7:0] CH_UN   = 8'h4E;  // N
  localparam logic [7:0] CH_UO   = 8'h4F;  // O
  localparam logic [7:0] CH_US   = 8'h53;  // S
  localparam logic [7:0] CH_UT   = 8'h54;  // T
  localparam logic [7:0] CH_UW   = 8'h57;  // W
  localparam logic [7:0] CH_LA   = 8'h61;  // a
  localparam logic [7:0] CH_LN   = 8'h6E;  // n
  localparam logic [7:0] CH_LP   = 8'h70;  // p
  localparam logic [7:0] CH_LR   = 8'h72;  // r
  localparam logic [7:0] CH_LU   = 8'h75;  // u

  localparam logic [0:0] REG_FIELD_BASE     = 1'd0;
  localparam logic [0:0] REG_SECONDS_OFFSET = 1'd1;

  typedef logic [SLOTS-1:0][7:0] cap_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } slot_t;

  typedef struct packed {
    logic [7:0] year_two_digit;
    logic [3:0] month_number;
    logic [7:0] day_of_month;
    logic [2:0] weekday_number;
    logic [7:0] hour_value;
    logic [7:0] minute_value;
    logic [7:0] second_value;
  } result_t;

  // offset from field base to capture slot
  function automatic slot_t slot_of(input logic [4:0] off);
    slot_t s;
    s.hit = 1'b1;
    s.idx = 4'd0;
    case (off)
      5'd0:  s.idx = 4'd0;
      5'd1:  s.idx = 4'd1;
      5'd4:  s.idx = 4'd2;
      5'd5:  s.idx = 4'd3;
      5'd6:  s.idx = 4'd4;
      5'd8:  s.idx = 4'd5;
      5'd9:  s.idx = 4'd6;
      5'd11: s.idx = 4'd7;
      5'd12: s.idx = 4'd8;
      5'd14: s.idx = 4'd9;
      5'd15: s.idx = 4'd10;
      5'd17: s.idx = 4'd11;
      5'd18: s.idx = 4'd12;
      5'd22: s.idx = 4'd13;
      5'd23: s.idx = 4'd14;
      default: s.hit = 1'b0;
    endcase
    return s;
  endfunction

  // two ascii digits to binary, modulo 256
  function automatic logic [7:0] digit_pair(input logic [7:0] tens, input logic [7:0] ones);
    logic [7:0] t;
    logic [7:0] o;
    t = tens - CH_ZERO;
    o = ones - CH_ZERO;
    return t * 8'd10 + o;
  endfunction

endpackage

// ===== design/atp_decode.sv =====
// atp_decode: turns the captured characters of one frame into a result word
// depends on atp_pkg
module atp_decode (
  input  atp_pkg::cap_t    cap,
  input  logic [5:0]       seconds_offset,
  output atp_pkg::result_t res
);
  import atp_pkg::*;

  logic [3:0] month;
  logic [2:0] weekday;
  logic [7:0] sec_raw;

  always_comb begin
    case (cap[2])
      CH_UJ: begin
        if (cap[3] == CH_LA) month = 4'd1;
        else if (cap[3] == CH_LU) month = (cap[4] == CH_LN) ? 4'd6 : 4'd7;
        else month = 4'd0;
      end
      CH_UF: month = 4'd2;
      CH_UM: month = (cap[4] == CH_LR) ? 4'd3 : 4'd5;
      CH_UA: month = (cap[3] == CH_LP) ? 4'd4 : 4'd8;
      CH_US: month = 4'd9;
      CH_UO: month = 4'd10;
      CH_UN: month = 4'd11;
      CH_UD: month = 4'd12;
      default: month = 4'd0;
    endcase
  end

  always_comb begin
    case (cap[0])
      CH_UM: weekday = 3'd1;
      CH_UT: weekday = (cap[1] == CH_LU) ? 3'd2 : 3'd4;
      CH_UW: weekday = 3'd3;
      CH_UF: weekday = 3'd5;
      CH_US: weekday = (cap[1] == CH_LA) ? 3'd6 : 3'd7;
      default: weekday = 3'd0;
    endcase
  end

  assign sec_raw = digit_pair(cap[11], cap[12]);

  always_comb begin
    res.year_two_digit = digit_pair(cap[13], cap[14]);
    res.month_number   = month;
    res.day_of_month   = digit_pair(cap[5], cap[6]);
    res.weekday_number = weekday;
    res.hour_value     = digit_pair(cap[7], cap[8]);
    res.minute_value   = digit_pair(cap[9], cap[10]);
    res.second_value   = sec_raw + {2'b00, seconds_offset};
  end

endmodule

// ===== design/ascii_timestamp_parser.sv =====
// ascii_timestamp_parser: position-counted capture of a time reply text, one result per frame
// depends on atp_pkg and atp_decode
//
//   channel  signals                                   direction
//   in       in_valid/in_ready, reply_byte, frame_last  byte stream in
//   out      out_valid/out_ready, seven result fields  one word per frame
//   cfg      cfg_write, cfg_index, cfg_data            register writes
//
// one byte per cycle sustained unless a last byte waits on an untaken result; a byte is
// registered, then captured and, on the last byte, decoded into the result register
// reset clears position, captures and both valids; field_base 13, seconds_offset 2
// only a last byte waits in the input register while the result word is not taken
module ascii_timestamp_parser #(
  parameter int FRAME_MAX = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] reply_byte,
  input  logic       frame_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] year_two_digit,
  output logic [3:0] month_number,
  output logic [7:0] day_of_month,
  output logic [2:0] weekday_number,
  output logic [7:0] hour_value,
  output logic [7:0] minute_value,
  output logic [7:0] second_value
);
  import atp_pkg::*;

  localparam int PW = $clog2(FRAME_MAX + 1);

  logic [5:0]    field_base;
  logic [5:0]    seconds_offset;
  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_last;
  logic          s1_fire;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic [PW-1:0] base_ext;
  logic [PW-1:0] off;
  slot_t         slot;
  logic          do_cap;
  cap_t          cap;
  cap_t          cap_next;
  result_t       dec;
  result_t       res;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_base     <= 6'd13;
      seconds_offset <= 6'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIELD_BASE:     field_base     <= cfg_data;
        REG_SECONDS_OFFSET: seconds_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_fire  = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= reply_byte;
      s1_last <= frame_last;
    end
  end

  // capture by position
  assign base_ext = PW'(field_base);
  assign off      = pos - base_ext;
  assign slot     = slot_of(off[4:0]);

  always_comb begin
    do_cap   = (pos < PW'(FRAME_MAX)) && (pos >= base_ext) && (off < PW'(SPAN)) && slot.hit;
    pos_next = (pos < PW'(FRAME_MAX)) ? pos + 1'b1 : pos;
    cap_next = cap;
    if (do_cap) begin
      cap_next[slot.idx] = s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      cap <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        pos <= '0;
        cap <= '0;
      end else begin
        pos <= pos_next;
        cap <= cap_next;
      end
    end
  end

  atp_decode u_decode (
    .cap            (cap_next),
    .seconds_offset (seconds_offset),
    .res            (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      res <= dec;
    end
  end

  assign year_two_digit = res.year_two_digit;
  assign month_number   = res.month_number;
  assign day_of_month   = res.day_of_month;
  assign weekday_number = res.weekday_number;
  assign hour_value     = res.hour_value;
  assign minute_value   = res.minute_value;
  assign second_value   = res.second_value;

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= PW'(FRAME_MAX))
    else $error("byte position beyond frame limit");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> pos == '0 && cap == '0)
    else $error("position or captures not cleared after last byte");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire && s1_last))
    else $error("result word without a last byte");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> month_number <= 4'd12)
    else $error("month number out of range");
`endif

endmodule
